// File: design/sequenced_ring_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sequenced ring queue
// Shared helpers that wrap a clocked implication with a reset disable.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_RING_QUEUE_CORE_MACROS_SVH
`define SEQUENCED_RING_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define SRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset
`define SRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/srq_pkg.sv
// ----------------------------------------------------------------------------
// Sequenced ring queue package
// Shared sizes, codes and payload types for the queue core and its parts.
// ----------------------------------------------------------------------------
package srq_pkg;

   // Cells of storage in the ring
   localparam int MAX_ENTRIES = 256;
   localparam int CELL_AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   // Largest ring size log2 that still fits in storage
   localparam int MAX_LG      = $clog2(MAX_ENTRIES + 1) - 1;
   localparam logic [3:0] LG_RESET = (MAX_LG < 8) ? 4'(MAX_LG) : 4'd8;
   // One cell word: sequence tag over handle
   localparam int CELL_W      = 64;

   // Operation codes
   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_SEQ   = 3'd3,
      ST_NULL  = 3'd4
   } status_type;

   typedef struct packed {
      logic        func;
      logic [31:0] msg_handle;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] msg_out;
      logic [8:0]  occupancy;
      logic [63:0] processed_total;
   } rsp_type;

   // Classified operation handed from the front end to the back end
   typedef struct packed {
      logic        is_remove;
      logic [31:0] handle;
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

// File: design/srq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/srq_front.sv
// ----------------------------------------------------------------------------
// Sequenced ring queue front end
// Accepts requests, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module srq_front
   import srq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    op_valid,
   input  logic    op_take,
   output op_type  op
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;
   op_type     op_new;

   // Classify the incoming request
   assign op_new.is_remove = (req_data.func == FUNC_REMOVE);
   assign op_new.handle    = req_data.msg_handle;

   assign req_full = (count_ff == 2'd2);
   assign op_valid = (count_ff != 2'd0);
   assign op       = slot_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = op_take && op_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

// File: design/srq_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Sequenced ring queue result queue
// Two-entry queue that holds results until the consumer pops them.
// ----------------------------------------------------------------------------
module srq_rsp_fifo
   import srq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    rsp_push,
   input  rsp_type rsp_in,
   output logic    rsp_room,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign rsp_room  = (count_ff != 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign do_push   = rsp_push && rsp_room;
   assign do_pop    = rsp_pop && !rsp_empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the result payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// File: design/srq_back.sv
// ----------------------------------------------------------------------------
// Sequenced ring queue back end
// Reads the addressed cell, checks its sequence tag, updates cell and counts.
// ----------------------------------------------------------------------------
module srq_back
   import srq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data,
   input  logic       op_valid,
   output logic       op_take,
   input  op_type     op,
   input  logic       rsp_room,
   output logic       rsp_push,
   output rsp_type    rsp
);

   back_state_type       state_ff, state_in;
   logic [3:0]           lg_ff, lg_in;
   logic [31:0]          add_pos_ff, add_pos_in;
   logic [31:0]          rem_pos_ff, rem_pos_in;
   logic [8:0]           count_ff, count_in;
   logic [63:0]          removed_ff, removed_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   op_type               op_ff, op_in;
   logic [CELL_AW-1:0]   idx_ff, idx_in;
   logic                 hit_ff, hit_in;

   logic [31:0]          ring_size;
   logic [31:0]          ring_mask;
   logic [31:0]          sel_pos;
   logic [CELL_AW-1:0]   rd_idx;
   logic [CELL_W-1:0]    rd_data;
   logic                 rd_en;
   logic                 wr_en;
   logic [CELL_W-1:0]    wr_data;
   logic [31:0]          cur_pos;
   logic [31:0]          cell_tag;
   logic [31:0]          cell_handle;
   logic [31:0]          tag_diff;
   logic                 csr_fire;
   logic [3:0]           csr_lg;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   // Clamp the requested size to what storage holds
   assign csr_lg    = (int'(csr_data) > MAX_LG) ? 4'(MAX_LG) : csr_data;

   assign ring_size = 32'd1 << lg_ff;
   assign ring_mask = ring_size - 32'd1;

   // Address the cell of the waiting operation
   assign sel_pos = op.is_remove ? rem_pos_ff : add_pos_ff;
   assign rd_idx  = sel_pos[CELL_AW-1:0] & ring_mask[CELL_AW-1:0];

   // Cell fields; an unwritten cell holds its reset contents
   assign cur_pos     = op_ff.is_remove ? rem_pos_ff : add_pos_ff;
   assign cell_tag    = hit_ff ? rd_data[63:32] : 32'(idx_ff);
   assign cell_handle = hit_ff ? rd_data[31:0] : 32'd0;
   assign tag_diff    = cell_tag - (op_ff.is_remove ? cur_pos + 32'd1 : cur_pos);

   srq_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAX_ENTRIES)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   // Sequence one operation: read the cell, then check and write back
   always_comb begin
      state_in   = state_ff;
      lg_in      = lg_ff;
      add_pos_in = add_pos_ff;
      rem_pos_in = rem_pos_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      valid_in   = valid_ff;
      op_in      = op_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      op_take    = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_data    = {cell_tag, cell_handle};
      rsp_push   = 1'b0;
      rsp.status = ST_OK;
      rsp.msg_out = 32'd0;

      case (state_ff)
         BK_IDLE: begin
            if (op_valid && rsp_room) begin
               op_take  = 1'b1;
               rd_en    = 1'b1;
               op_in    = op;
               idx_in   = rd_idx;
               hit_in   = valid_ff[rd_idx];
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            rsp_push = 1'b1;
            state_in = BK_IDLE;
            if (!op_ff.is_remove) begin
               if (tag_diff == 32'd0) begin
                  wr_en      = 1'b1;
                  wr_data    = {cur_pos + 32'd1, op_ff.handle};
                  add_pos_in = cur_pos + 32'd1;
                  count_in   = count_ff + 9'd1;
               end else if (tag_diff[31]) begin
                  rsp.status = ST_FULL;
               end else begin
                  rsp.status = ST_SEQ;
               end
            end else begin
               if (tag_diff[31]) begin
                  rsp.status = ST_EMPTY;
               end else if (tag_diff != 32'd0) begin
                  rsp.status = ST_SEQ;
               end else begin
                  wr_en       = 1'b1;
                  wr_data     = {cur_pos + ring_size, cell_handle};
                  rem_pos_in  = cur_pos + 32'd1;
                  count_in    = count_ff - 9'd1;
                  removed_in  = removed_ff + 64'd1;
                  rsp.msg_out = cell_handle;
                  if (cell_handle == 32'd0) begin
                     rsp.status = ST_NULL;
                  end
               end
            end
            if (wr_en) begin
               valid_in[idx_ff] = 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // Reinitialize the ring on a size write
      if (csr_fire) begin
         lg_in      = csr_lg;
         add_pos_in = 32'd0;
         rem_pos_in = 32'd0;
         count_in   = 9'd0;
         removed_in = 64'd0;
         valid_in   = '0;
         state_in   = BK_IDLE;
      end

      // Report the counts after this operation
      rsp.occupancy       = count_in;
      rsp.processed_total = removed_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         lg_ff      <= LG_RESET;
         add_pos_ff <= 32'd0;
         rem_pos_ff <= 32'd0;
         count_ff   <= 9'd0;
         removed_ff <= 64'd0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         lg_ff      <= lg_in;
         add_pos_ff <= add_pos_in;
         rem_pos_ff <= rem_pos_in;
         count_ff   <= count_in;
         removed_ff <= removed_in;
         valid_ff   <= valid_in;
      end
   end

   // Operation in flight
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
   end

endmodule

// File: design/sequenced_ring_queue_core.sv
// ----------------------------------------------------------------------------
// Sequenced ring queue core
// Bounded ring of message handles guarded by per-cell sequence tags.
// ----------------------------------------------------------------------------
// In the back end, state BK_IDLE reads the addressed cell from the cell
// memory and state BK_EXEC checks its tag and writes it back; the back end
// takes no new request until it is through with the last. A two-entry request
// queue and a two-entry result queue decouple both sides, so requests are
// taken while results wait to be popped. Reset and size writes reinitialize
// the ring at once through per-cell valid bits; no clearing pass is needed.
module sequenced_ring_queue_core
   import srq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   logic    op_valid;
   logic    op_take;
   op_type  op;
   logic    rsp_room;
   logic    rsp_push;
   rsp_type rsp;

   srq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .op_valid (op_valid),
      .op_take  (op_take),
      .op       (op)
   );

   srq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .op_valid  (op_valid),
      .op_take   (op_take),
      .op        (op),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   srq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_in    (rsp),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/srq_checker.sv
// ----------------------------------------------------------------------------
// Sequenced ring queue checker
// Port-level checks on the queue core, attached by bind.
// ----------------------------------------------------------------------------
`include "sequenced_ring_queue_core_macros.svh"

module srq_checker
   import srq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input rsp_type    rsp_data
);

   // Reset leaves the result queue empty and the request queue not full
   `SRQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full, "queues not empty after reset")

   // Hold a waiting result until it is popped
   `SRQ_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "waiting result changed or dropped")

   // Only a clean remove returns a handle
   `SRQ_ASSERT_IMPLY(a_handle_ok, clock, reset, !rsp_empty && rsp_data.msg_out != 32'd0, rsp_data.status == ST_OK, "handle returned with a failing status")

endmodule

bind sequenced_ring_queue_core srq_checker u_srq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
